@@ sv/rtfd_pkg.sv @@
package rtfd_pkg;

    localparam int FRAME_W = 59;

    localparam logic [4:0] RESYNC_HOUR_RST   = 5'd5;
    localparam logic [5:0] RESYNC_MINUTE_RST = 6'd30;

    typedef enum logic [1:0] {
        CMD_DECODE   = 2'd0,
        CMD_CHECK    = 2'd1,
        CMD_SET_MARK = 2'd2,
        CMD_NONE     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_SET    = 2'd1,
        ST_RSVD_A = 2'd2,
        ST_RSVD_B = 2'd3
    } t_status;

    typedef enum logic {
        CFG_RESYNC_HOUR   = 1'b0,
        CFG_RESYNC_MINUTE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]         command;
        logic [FRAME_W-1:0] frame_bits;
        logic [4:0]         rtc_hours;
        logic [5:0]         rtc_minutes;
        logic [1:0]         status_value;
    } t_item;

    typedef struct packed {
        logic       minute_parity_ok;
        logic       hour_parity_ok;
        logic       date_parity_ok;
        logic       frame_ok;
        logic       rtc_write;
        logic [6:0] minute_value;
        logic [5:0] hour_value;
        logic [5:0] day_value;
        logic [4:0] month_value;
        logic [7:0] year_value;
        logic       summer_time;
        logic       time_set;
    } t_result;

    typedef struct packed {
        logic mark;
        logic summer;
    } t_state;

endpackage

@@ sv/rtfd_if.sv @@
interface rtfd_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [rtfd_pkg::FRAME_W-1:0]  frame_bits;
    logic [4:0]                    rtc_hours;
    logic [5:0]                    rtc_minutes;
    logic [1:0]                    status_value;

    modport source (output valid, command, frame_bits, rtc_hours, rtc_minutes,
                    status_value, input ready);
    modport sink   (input valid, command, frame_bits, rtc_hours, rtc_minutes,
                    status_value, output ready);
endinterface

interface rtfd_out_if;
    logic       valid;
    logic       ready;
    logic       minute_parity_ok;
    logic       hour_parity_ok;
    logic       date_parity_ok;
    logic       frame_ok;
    logic       rtc_write;
    logic [6:0] minute_value;
    logic [5:0] hour_value;
    logic [5:0] day_value;
    logic [4:0] month_value;
    logic [7:0] year_value;
    logic       summer_time;
    logic       time_set;

    modport source (output valid, minute_parity_ok, hour_parity_ok, date_parity_ok,
                    frame_ok, rtc_write, minute_value, hour_value, day_value,
                    month_value, year_value, summer_time, time_set, input ready);
    modport sink   (input valid, minute_parity_ok, hour_parity_ok, date_parity_ok,
                    frame_ok, rtc_write, minute_value, hour_value, day_value,
                    month_value, year_value, summer_time, time_set, output ready);
endinterface

interface rtfd_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [5:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/radio_time_frame_decoder.sv @@
// Channel | Dir | Payload                                       | Handshake
// i_in    | in  | command, frame_bits, rtc_hours/minutes, status | valid/ready
// o_out   | out | parity flags, frame_ok, rtc_write, binary values | valid/ready
// i_cfg   | in  | index (0 resync hour, 1 resync minute), data   | valid/ready
//
// One request per cycle sustained while results are taken. The input register
// loads at acceptance and the result register as it advances, raising o_out.valid.
// Synchronous active-low reset clears valids, the time-set mark, the summer flag
// and loads resync time 05:30. Config ready is always high.
// Output stall backs up through the input register; input ready falls only when
// both stages hold a request and the result is not taken.
module radio_time_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rtfd_in_if.sink     i_in,
    rtfd_out_if.source  o_out,
    rtfd_cfg_if.sink    i_cfg
);

    logic              r_s1_valid;
    rtfd_pkg::t_item   r_item;
    logic              r_out_valid;
    rtfd_pkg::t_result r_result;
    rtfd_pkg::t_state  r_state;
    logic [4:0]        r_resync_hour;
    logic [5:0]        r_resync_minute;

    rtfd_pkg::t_result n_result;
    rtfd_pkg::t_state  n_state;
    logic              s1_adv;
    logic              s1_fire;

    assign s1_adv    = !r_out_valid || o_out.ready;
    assign s1_fire   = s1_adv && r_s1_valid;
    assign i_in.ready  = !r_s1_valid || s1_adv;
    assign i_cfg.ready = 1'b1;

    rtfd_decode u_decode (
        .i_item          (r_item),
        .i_state         (r_state),
        .i_resync_hour   (r_resync_hour),
        .i_resync_minute (r_resync_minute),
        .o_result        (n_result),
        .o_state         (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_state         <= '0;
            r_resync_hour   <= rtfd_pkg::RESYNC_HOUR_RST;
            r_resync_minute <= rtfd_pkg::RESYNC_MINUTE_RST;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
            // state commits when its request moves into the result register
            if (s1_fire) begin
                r_state <= n_state;
            end
            if (i_cfg.valid) begin
                unique case (rtfd_pkg::t_cfg_idx'(i_cfg.index))
                    rtfd_pkg::CFG_RESYNC_HOUR:   r_resync_hour   <= i_cfg.data[4:0];
                    rtfd_pkg::CFG_RESYNC_MINUTE: r_resync_minute <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.command      <= i_in.command;
            r_item.frame_bits   <= i_in.frame_bits;
            r_item.rtc_hours    <= i_in.rtc_hours;
            r_item.rtc_minutes  <= i_in.rtc_minutes;
            r_item.status_value <= i_in.status_value;
        end
        if (s1_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.minute_parity_ok = r_result.minute_parity_ok;
    assign o_out.hour_parity_ok   = r_result.hour_parity_ok;
    assign o_out.date_parity_ok   = r_result.date_parity_ok;
    assign o_out.frame_ok         = r_result.frame_ok;
    assign o_out.rtc_write        = r_result.rtc_write;
    assign o_out.minute_value     = r_result.minute_value;
    assign o_out.hour_value       = r_result.hour_value;
    assign o_out.day_value        = r_result.day_value;
    assign o_out.month_value      = r_result.month_value;
    assign o_out.year_value       = r_result.year_value;
    assign o_out.summer_time      = r_result.summer_time;
    assign o_out.time_set         = r_result.time_set;

endmodule

@@ sv/rtfd_decode.sv @@
module rtfd_decode (
    input  rtfd_pkg::t_item   i_item,
    input  rtfd_pkg::t_state  i_state,
    input  logic [4:0]        i_resync_hour,
    input  logic [5:0]        i_resync_minute,
    output rtfd_pkg::t_result o_result,
    output rtfd_pkg::t_state  o_state
);

    logic [rtfd_pkg::FRAME_W-1:0] f;
    logic                         pm, ph, pd, all_ok;
    rtfd_pkg::t_state             st;
    rtfd_pkg::t_result            res;

    assign f = i_item.frame_bits;

    // even parity over each group must match its parity bit
    assign pm     = ((^f[27:21]) == f[28]);
    assign ph     = ((^f[34:29]) == f[35]);
    assign pd     = ((^f[57:36]) == f[58]);
    assign all_ok = pm & ph & pd;

    always_comb begin
        st  = i_state;
        res = '0;
        unique case (rtfd_pkg::t_cmd'(i_item.command))
            rtfd_pkg::CMD_DECODE: begin
                res.minute_parity_ok = pm;
                res.hour_parity_ok   = ph;
                res.date_parity_ok   = pd;
                if (all_ok) begin
                    res.frame_ok = 1'b1;
                    if (f[17]) begin
                        st.summer = 1'b1;
                    end else if (f[18]) begin
                        st.summer = 1'b0;
                    end
                    res.minute_value = 7'(f[24:21]) + 7'(f[27:25]) * 7'd10;
                    res.hour_value   = 6'(f[32:29]) + 6'(f[34:33]) * 6'd10;
                    res.day_value    = 6'(f[39:36]) + 6'(f[41:40]) * 6'd10;
                    res.month_value  = 5'(f[48:45]) + (f[49] ? 5'd10 : 5'd0);
                    res.year_value   = 8'(f[53:50]) + 8'(f[57:54]) * 8'd10;
                    if (!i_state.mark) begin
                        res.rtc_write = 1'b1;
                        st.mark       = 1'b1;
                    end
                end
            end
            rtfd_pkg::CMD_CHECK: begin
                if (i_item.rtc_hours == i_resync_hour &&
                    i_item.rtc_minutes == i_resync_minute) begin
                    st.mark = 1'b0;
                end
            end
            rtfd_pkg::CMD_SET_MARK: begin
                unique case (rtfd_pkg::t_status'(i_item.status_value))
                    rtfd_pkg::ST_CLEAR: st.mark = 1'b0;
                    rtfd_pkg::ST_SET:   st.mark = 1'b1;
                    default:            st.mark = i_state.mark;
                endcase
            end
            default: st = i_state;
        endcase
        res.summer_time = st.summer;
        res.time_set    = st.mark;
    end

    assign o_result = res;
    assign o_state  = st;

endmodule

@@ sv/rtfd_checker.sv @@
module rtfd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_pm_ok,
    input logic       i_ph_ok,
    input logic       i_pd_ok,
    input logic       i_frame_ok,
    input logic       i_rtc_write,
    input logic       i_time_set,
    input logic [6:0] i_minute,
    input logic [7:0] i_year
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // clock load only on a good frame, and it leaves the mark set
    a_write_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_rtc_write |-> i_frame_ok && i_time_set)
        else $error("rtc_write without good frame or mark");

    a_frame_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_ok |-> i_pm_ok && i_ph_ok && i_pd_ok)
        else $error("frame_ok with a failed parity group");

    // failed frames carry no decoded time
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_frame_ok |-> i_minute == 7'd0 && i_year == 8'd0 && !i_rtc_write)
        else $error("decoded values on a failed frame");

endmodule

bind radio_time_frame_decoder rtfd_checker u_rtfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_pm_ok     (o_out.minute_parity_ok),
    .i_ph_ok     (o_out.hour_parity_ok),
    .i_pd_ok     (o_out.date_parity_ok),
    .i_frame_ok  (o_out.frame_ok),
    .i_rtc_write (o_out.rtc_write),
    .i_time_set  (o_out.time_set),
    .i_minute    (o_out.minute_value),
    .i_year      (o_out.year_value)
);

@@ bench/radio_time_frame_decoder_tb.sv @@
`timescale 1ns / 1ps

module radio_time_frame_decoder_tb;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 10;
    localparam int LATENCY         = 2;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int MIN_PARITY_BIT  = 28;
    localparam int HOUR_PARITY_BIT = 35;
    localparam int DATE_PARITY_BIT = 58;
    localparam int SUMMER_ON_BIT   = 17;
    localparam int SUMMER_OFF_BIT  = 18;

    logic i_clk;
    logic i_rst_n;

    rtfd_in_if  in_if();
    rtfd_out_if out_if();
    rtfd_cfg_if cfg_if();

    radio_time_frame_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // decoder state as the testbench expects it
    logic       mark_state;
    logic       summer_state;
    logic [4:0] cfg_hour;
    logic [5:0] cfg_minute;

    rtfd_pkg::t_result expected_results[$];
    int                mismatch_count;
    int                cycle_count;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                hold_left;

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random idling plus an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(string what, longint unsigned got, longint unsigned want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    function automatic rtfd_pkg::t_result decode_expected(rtfd_pkg::t_item req);
        rtfd_pkg::t_result            res;
        logic [rtfd_pkg::FRAME_W-1:0] f;
        logic                         pm;
        logic                         ph;
        logic                         pd;
        res = '0;
        f = req.frame_bits;
        case (req.command)
            rtfd_pkg::CMD_DECODE: begin
                pm = ((^f[27:21]) == f[MIN_PARITY_BIT]);
                ph = ((^f[34:29]) == f[HOUR_PARITY_BIT]);
                pd = ((^f[57:36]) == f[DATE_PARITY_BIT]);
                res.minute_parity_ok = pm;
                res.hour_parity_ok   = ph;
                res.date_parity_ok   = pd;
                if (pm && ph && pd) begin
                    res.frame_ok = 1'b1;
                    if (f[SUMMER_ON_BIT])
                        summer_state = 1'b1;
                    else if (f[SUMMER_OFF_BIT])
                        summer_state = 1'b0;
                    res.minute_value = 7'(f[24:21]) + 7'(f[27:25]) * 7'd10;
                    res.hour_value   = 6'(f[32:29]) + 6'(f[34:33]) * 6'd10;
                    res.day_value    = 6'(f[39:36]) + 6'(f[41:40]) * 6'd10;
                    res.month_value  = 5'(f[48:45]) + (f[49] ? 5'd10 : 5'd0);
                    res.year_value   = 8'(f[53:50]) + 8'(f[57:54]) * 8'd10;
                    if (!mark_state) begin
                        res.rtc_write = 1'b1;
                        mark_state = 1'b1;
                    end
                end
            end
            rtfd_pkg::CMD_CHECK: begin
                if (req.rtc_hours == cfg_hour && req.rtc_minutes == cfg_minute)
                    mark_state = 1'b0;
            end
            rtfd_pkg::CMD_SET_MARK: begin
                if (req.status_value == rtfd_pkg::ST_CLEAR)
                    mark_state = 1'b0;
                else if (req.status_value == rtfd_pkg::ST_SET)
                    mark_state = 1'b1;
            end
            default: ;
        endcase
        res.summer_time = summer_state;
        res.time_set    = mark_state;
        return res;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        rtfd_pkg::t_item   req;
        rtfd_pkg::t_result got;
        rtfd_pkg::t_result want;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                if (cfg_if.index == rtfd_pkg::CFG_RESYNC_HOUR)
                    cfg_hour = cfg_if.data[4:0];
                else
                    cfg_minute = cfg_if.data;
            end
            if (in_if.valid && in_if.ready) begin
                req.command      = in_if.command;
                req.frame_bits   = in_if.frame_bits;
                req.rtc_hours    = in_if.rtc_hours;
                req.rtc_minutes  = in_if.rtc_minutes;
                req.status_value = in_if.status_value;
                expected_results.push_back(decode_expected(req));
            end
            if (out_if.valid && out_if.ready) begin
                got.minute_parity_ok = out_if.minute_parity_ok;
                got.hour_parity_ok   = out_if.hour_parity_ok;
                got.date_parity_ok   = out_if.date_parity_ok;
                got.frame_ok         = out_if.frame_ok;
                got.rtc_write        = out_if.rtc_write;
                got.minute_value     = out_if.minute_value;
                got.hour_value       = out_if.hour_value;
                got.day_value        = out_if.day_value;
                got.month_value      = out_if.month_value;
                got.year_value       = out_if.year_value;
                got.summer_time      = out_if.summer_time;
                got.time_set         = out_if.time_set;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    check_field("minute_parity_ok", got.minute_parity_ok,
                                want.minute_parity_ok);
                    check_field("hour_parity_ok", got.hour_parity_ok, want.hour_parity_ok);
                    check_field("date_parity_ok", got.date_parity_ok, want.date_parity_ok);
                    check_field("frame_ok", got.frame_ok, want.frame_ok);
                    check_field("rtc_write", got.rtc_write, want.rtc_write);
                    check_field("minute_value", got.minute_value, want.minute_value);
                    check_field("hour_value", got.hour_value, want.hour_value);
                    check_field("day_value", got.day_value, want.day_value);
                    check_field("month_value", got.month_value, want.month_value);
                    check_field("year_value", got.year_value, want.year_value);
                    check_field("summer_time", got.summer_time, want.summer_time);
                    check_field("time_set", got.time_set, want.time_set);
                end
            end
        end
    end

    function automatic logic [rtfd_pkg::FRAME_W-1:0] random_frame();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[rtfd_pkg::FRAME_W-1:0];
    endfunction

    // make all three parity groups pass
    function automatic logic [rtfd_pkg::FRAME_W-1:0] seal_parity(
        logic [rtfd_pkg::FRAME_W-1:0] f);
        f[MIN_PARITY_BIT]  = ^f[27:21];
        f[HOUR_PARITY_BIT] = ^f[34:29];
        f[DATE_PARITY_BIT] = ^f[57:36];
        return f;
    endfunction

    function automatic rtfd_pkg::t_item make_req(rtfd_pkg::t_cmd cmd,
                                                 logic [rtfd_pkg::FRAME_W-1:0] f,
                                                 logic [4:0] hrs, logic [5:0] mins,
                                                 rtfd_pkg::t_status st);
        rtfd_pkg::t_item req;
        req.command      = cmd;
        req.frame_bits   = f;
        req.rtc_hours    = hrs;
        req.rtc_minutes  = mins;
        req.status_value = st;
        return req;
    endfunction

    function automatic rtfd_pkg::t_item random_req();
        int                           pick;
        logic [rtfd_pkg::FRAME_W-1:0] f;
        logic [4:0]                   hrs;
        logic [5:0]                   mins;
        rtfd_pkg::t_status            st;
        pick = $urandom_range(99);
        f    = random_frame();
        hrs  = 5'($urandom_range(23));
        mins = 6'($urandom_range(59));
        st   = rtfd_pkg::t_status'($urandom_range(3));
        if (pick < 55)
            return make_req(rtfd_pkg::CMD_DECODE, seal_parity(f), hrs, mins, st);
        if (pick < 65) begin
            f = seal_parity(f);
            case ($urandom_range(3))
                0: f[MIN_PARITY_BIT]  = ~f[MIN_PARITY_BIT];
                1: f[HOUR_PARITY_BIT] = ~f[HOUR_PARITY_BIT];
                2: f[DATE_PARITY_BIT] = ~f[DATE_PARITY_BIT];
                default: f = random_frame();
            endcase
            return make_req(rtfd_pkg::CMD_DECODE, f, hrs, mins, st);
        end
        if (pick < 80) begin
            if ($urandom_range(1)) begin
                hrs  = cfg_hour;
                mins = cfg_minute;
            end
            return make_req(rtfd_pkg::CMD_CHECK, f, hrs, mins, st);
        end
        if (pick < 92)
            return make_req(rtfd_pkg::CMD_SET_MARK, f, hrs, mins, st);
        return make_req(rtfd_pkg::CMD_NONE, f, hrs, mins, st);
    endfunction

    task automatic send_req(rtfd_pkg::t_item req);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.command      <= req.command;
        in_if.frame_bits   <= req.frame_bits;
        in_if.rtc_hours    <= req.rtc_hours;
        in_if.rtc_minutes  <= req.rtc_minutes;
        in_if.status_value <= req.status_value;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_resync(rtfd_pkg::t_cfg_idx idx, logic [5:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // reset resync time 05:30, every command and special case
    task automatic test_directed_cases();
        logic [rtfd_pkg::FRAME_W-1:0] f;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_req(make_req(rtfd_pkg::CMD_DECODE, '0, 5'd0, 6'd0, rtfd_pkg::ST_CLEAR));
        send_req(make_req(rtfd_pkg::CMD_DECODE, seal_parity(59'd1 << SUMMER_ON_BIT),
                          5'd23, 6'd59, rtfd_pkg::ST_SET));
        send_req(make_req(rtfd_pkg::CMD_DECODE, seal_parity(59'd1 << SUMMER_OFF_BIT),
                          5'd0, 6'd0, rtfd_pkg::ST_CLEAR));
        // all field bits set: all-ones BCD digits, both summer bits
        send_req(make_req(rtfd_pkg::CMD_DECODE, seal_parity('1), 5'd5, 6'd30,
                          rtfd_pkg::ST_RSVD_B));
        send_req(make_req(rtfd_pkg::CMD_DECODE, seal_parity('0), 5'd5, 6'd30,
                          rtfd_pkg::ST_CLEAR));
        send_req(make_req(rtfd_pkg::CMD_DECODE, '1, 5'd5, 6'd30, rtfd_pkg::ST_CLEAR));
        f = seal_parity(random_frame() | (59'd1 << SUMMER_OFF_BIT));
        f[SUMMER_ON_BIT] = 1'b0;
        f = seal_parity(f);
        send_req(make_req(rtfd_pkg::CMD_DECODE, f ^ (59'd1 << MIN_PARITY_BIT), 5'd0, 6'd0,
                          rtfd_pkg::ST_CLEAR));
        send_req(make_req(rtfd_pkg::CMD_DECODE, f ^ (59'd1 << HOUR_PARITY_BIT), 5'd0, 6'd0,
                          rtfd_pkg::ST_CLEAR));
        send_req(make_req(rtfd_pkg::CMD_DECODE, f ^ (59'd1 << DATE_PARITY_BIT), 5'd0, 6'd0,
                          rtfd_pkg::ST_CLEAR));
        send_req(make_req(rtfd_pkg::CMD_CHECK, random_frame(), 5'd5, 6'd31,
                          rtfd_pkg::ST_CLEAR));
        send_req(make_req(rtfd_pkg::CMD_CHECK, random_frame(), 5'd4, 6'd30,
                          rtfd_pkg::ST_CLEAR));
        send_req(make_req(rtfd_pkg::CMD_CHECK, random_frame(), 5'd5, 6'd30,
                          rtfd_pkg::ST_SET));
        send_req(make_req(rtfd_pkg::CMD_DECODE, seal_parity(random_frame()), 5'd0, 6'd0,
                          rtfd_pkg::ST_CLEAR));
        send_req(make_req(rtfd_pkg::CMD_SET_MARK, random_frame(), 5'd0, 6'd0,
                          rtfd_pkg::ST_RSVD_A));
        send_req(make_req(rtfd_pkg::CMD_SET_MARK, random_frame(), 5'd0, 6'd0,
                          rtfd_pkg::ST_RSVD_B));
        send_req(make_req(rtfd_pkg::CMD_SET_MARK, random_frame(), 5'd0, 6'd0,
                          rtfd_pkg::ST_CLEAR));
        send_req(make_req(rtfd_pkg::CMD_SET_MARK, random_frame(), 5'd0, 6'd0,
                          rtfd_pkg::ST_RSVD_B));
        send_req(make_req(rtfd_pkg::CMD_SET_MARK, random_frame(), 5'd0, 6'd0,
                          rtfd_pkg::ST_SET));
        send_req(make_req(rtfd_pkg::CMD_SET_MARK, random_frame(), 5'd0, 6'd0,
                          rtfd_pkg::ST_CLEAR));
        send_req(make_req(rtfd_pkg::CMD_NONE, '1, 5'd5, 6'd30, rtfd_pkg::ST_SET));
        send_req(make_req(rtfd_pkg::CMD_DECODE, f, 5'd23, 6'd59, rtfd_pkg::ST_RSVD_A));
        send_req(make_req(rtfd_pkg::CMD_NONE, '0, 5'd23, 6'd59, rtfd_pkg::ST_CLEAR));
        wait_drained();
    endtask

    task automatic test_resync_registers();
        write_resync(rtfd_pkg::CFG_RESYNC_HOUR, 6'd0);
        write_resync(rtfd_pkg::CFG_RESYNC_MINUTE, 6'd0);
        send_req(make_req(rtfd_pkg::CMD_SET_MARK, '0, 5'd0, 6'd0, rtfd_pkg::ST_SET));
        send_req(make_req(rtfd_pkg::CMD_CHECK, '0, 5'd0, 6'd1, rtfd_pkg::ST_CLEAR));
        send_req(make_req(rtfd_pkg::CMD_CHECK, '0, 5'd0, 6'd0, rtfd_pkg::ST_SET));
        wait_drained();
        write_resync(rtfd_pkg::CFG_RESYNC_HOUR, 6'd23);
        write_resync(rtfd_pkg::CFG_RESYNC_MINUTE, 6'd59);
        send_req(make_req(rtfd_pkg::CMD_SET_MARK, '1, 5'd23, 6'd59, rtfd_pkg::ST_SET));
        send_req(make_req(rtfd_pkg::CMD_CHECK, '1, 5'd23, 6'd58, rtfd_pkg::ST_CLEAR));
        send_req(make_req(rtfd_pkg::CMD_CHECK, '1, 5'd22, 6'd59, rtfd_pkg::ST_CLEAR));
        send_req(make_req(rtfd_pkg::CMD_CHECK, '1, 5'd23, 6'd59, rtfd_pkg::ST_SET));
        wait_drained();
    endtask

    task automatic test_random_traffic(int count, int send_pct, int recv_pct,
                                       logic [4:0] hour, logic [5:0] minute);
        write_resync(rtfd_pkg::CFG_RESYNC_HOUR, {1'b0, hour});
        write_resync(rtfd_pkg::CFG_RESYNC_MINUTE, minute);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_req(random_req());
        wait_drained();
    endtask

    // receiver stops for a long stretch; the decoder fills and drops input ready
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge i_clk);
        hold_left = 300;
        repeat (60) send_req(random_req());
        wait_drained();
    endtask

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.command      = rtfd_pkg::CMD_DECODE;
        in_if.frame_bits   = '0;
        in_if.rtc_hours    = '0;
        in_if.rtc_minutes  = '0;
        in_if.status_value = rtfd_pkg::ST_CLEAR;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = rtfd_pkg::CFG_RESYNC_HOUR;
        cfg_if.data        = '0;
        out_if.ready       = 1'b0;
        mark_state         = 1'b0;
        summer_state       = 1'b0;
        cfg_hour           = rtfd_pkg::RESYNC_HOUR_RST;
        cfg_minute         = rtfd_pkg::RESYNC_MINUTE_RST;
        mismatch_count     = 0;
        cycle_count        = 0;
        send_idle_pct      = 0;
        recv_idle_pct      = 0;
        hold_left          = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_resync_registers();
        test_random_traffic(540, 14, 88, 5'd12, 6'd45);
        test_random_traffic(540, 88, 14, 5'd23, 6'd59);
        test_random_traffic(540, 0, 0, 5'd0, 6'd0);
        test_output_backpressure();

        if (expected_results.size() != 0)
            report_mismatch("results never delivered", expected_results.size(), 0);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
